@@ design/svau_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svau_pkg
// Shared widths, stage numbering and register codes of the spectral
// vorticity update pipeline.
// ----------------------------------------------------------------------------
package svau_pkg;

	// pipeline layout: stage 1 input, 12..27 divider, 28 output
	localparam int N_STG     = 28;
	localparam int DIV_FIRST = 12;
	localparam int DIV_STG   = 16;
	localparam int DIV_BITS  = 2;

	// configuration register codes and reset values
	localparam logic [1:0] CFG_VISC = 2'd0;
	localparam logic [1:0] CFG_INV  = 2'd1;
	localparam logic [1:0] CFG_UWSQ = 2'd2;

	localparam logic [30:0] VISC_RST = 31'd3277;
	localparam logic [30:0] INV_RST  = 31'd4194304;
	localparam logic [30:0] UWSQ_RST = 31'd2587238;

	// per-stage load enables, index = stage number
	typedef logic [N_STG:1] stage_en_t;

	// status of one part handed to the divider
	typedef struct packed {
		logic nneg;   // numerator negative
		logic ovf;    // quotient does not fit 32 bits
		logic nzero;  // numerator zero
		logic dzero;  // divisor zero
	} div_flags_t;

endpackage

`default_nettype wire

@@ design/svau_coef.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svau_coef
// Stages 2..5: squared wavenumber, diffusion term, and the signed factor and
// divisor shared by both parts.
// ----------------------------------------------------------------------------
module svau_coef (
	input  wire                  clk,
	input  svau_pkg::stage_en_t  en,
	input  wire  [15:0]          msq_s1,
	input  wire  [30:0]          visc,
	input  wire  [30:0]          inv,
	input  wire  [30:0]          uwsq,
	output logic [59:0]          am_s5,
	output logic                 aneg_s5,
	output logic [60:0]          den_s5
);
	import svau_pkg::*;

	logic [45:0] ksq_s2;
	logic [53:0] plo_s3;
	logic [53:0] phi_s3;
	logic [59:0] temp_s4;
	logic [76:0] prod;

	assign prod = 77'(plo_s3) + {phi_s3, 23'd0};

	// ksq, split product with viscosity, temp, factor and divisor
	always_ff @(posedge clk) begin
		if (en[2]) begin
			ksq_s2 <= 46'(msq_s1) * 46'(uwsq);
		end
		if (en[3]) begin
			plo_s3 <= 54'(ksq_s2[22:0]) * 54'(visc);
			phi_s3 <= 54'(ksq_s2[45:23]) * 54'(visc);
		end
		if (en[4]) begin
			temp_s4 <= prod[76:17];
		end
		if (en[5]) begin
			aneg_s5 <= temp_s4 > 60'(inv);
			am_s5   <= (temp_s4 > 60'(inv)) ? temp_s4 - 60'(inv) : 60'(inv) - temp_s4;
			den_s5  <= 61'(temp_s4) + 61'(inv);
		end
	end

endmodule

`default_nettype wire

@@ design/svau_numer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svau_numer
// Stages 2..11 of one part: numerator 2*a*w - 2f*2^16, its magnitude plus the
// rounding offset, and the range check before the divider.
// ----------------------------------------------------------------------------
module svau_numer (
	input  wire                   clk,
	input  svau_pkg::stage_en_t   en,
	input  wire                   wneg_s1,
	input  wire  [31:0]           wm_s1,
	input  wire  signed [34:0]    f2_s1,
	input  wire  [59:0]           am_s5,
	input  wire                   aneg_s5,
	input  wire  [60:0]           den_s5,
	output logic [61:0]           rem_s11,
	output logic [31:0]           nlo_s11,
	output logic [61:0]           d2_s11,
	output svau_pkg::div_flags_t  flg_s11
);
	import svau_pkg::*;

	logic               wneg_s2, wneg_s3, wneg_s4, wneg_s5;
	logic [31:0]        wm_s2, wm_s3, wm_s4, wm_s5;
	logic signed [34:0] f2_s2, f2_s3, f2_s4, f2_s5, f2_s6, f2_s7;
	logic [61:0]        p0_s6, p1_s6;
	logic               neg_s6, neg_s7;
	logic [60:0]        den_s6, den_s7, den_s8, den_s9;
	logic [91:0]        mag_s7;
	logic signed [95:0] n_s8;
	logic               nneg_s9;
	logic [94:0]        nm_s9;
	logic [95:0]        nbig_s10;
	logic [61:0]        d2_s10;
	logic               nneg_s10, nzero_s10, dzero_s10;
	logic [95:0]        pm;
	logic [95:0]        fx;

	assign pm = {3'd0, mag_s7, 1'b0};
	assign fx = {{45{f2_s7[34]}}, f2_s7, 16'd0};

	// carry the part's inputs alongside the coefficient stages
	always_ff @(posedge clk) begin
		if (en[2]) begin
			wneg_s2 <= wneg_s1; wm_s2 <= wm_s1; f2_s2 <= f2_s1;
		end
		if (en[3]) begin
			wneg_s3 <= wneg_s2; wm_s3 <= wm_s2; f2_s3 <= f2_s2;
		end
		if (en[4]) begin
			wneg_s4 <= wneg_s3; wm_s4 <= wm_s3; f2_s4 <= f2_s3;
		end
		if (en[5]) begin
			wneg_s5 <= wneg_s4; wm_s5 <= wm_s4; f2_s5 <= f2_s4;
		end
	end

	// split product, combine, signed numerator
	always_ff @(posedge clk) begin
		if (en[6]) begin
			p0_s6  <= 62'(am_s5[29:0]) * 62'(wm_s5);
			p1_s6  <= 62'(am_s5[59:30]) * 62'(wm_s5);
			neg_s6 <= aneg_s5 ^ wneg_s5;
			f2_s6  <= f2_s5;
			den_s6 <= den_s5;
		end
		if (en[7]) begin
			mag_s7 <= 92'(p0_s6) + {p1_s6, 30'd0};
			neg_s7 <= neg_s6;
			f2_s7  <= f2_s6;
			den_s7 <= den_s6;
		end
		if (en[8]) begin
			n_s8   <= signed'((neg_s7 ? 96'd0 - pm : pm) - fx);
			den_s8 <= den_s7;
		end
	end

	// magnitude, rounding offset, range check
	always_ff @(posedge clk) begin
		if (en[9]) begin
			nneg_s9 <= n_s8[95];
			nm_s9   <= n_s8[95] ? 95'(96'd0 - unsigned'(n_s8)) : n_s8[94:0];
			den_s9  <= den_s8;
		end
		if (en[10]) begin
			nbig_s10  <= 96'(nm_s9) + 96'(den_s9);
			nzero_s10 <= nm_s9 == '0;
			dzero_s10 <= den_s9 == '0;
			d2_s10    <= {den_s9, 1'b0};
			nneg_s10  <= nneg_s9;
		end
		if (en[11]) begin
			rem_s11       <= nbig_s10[93:32];
			nlo_s11       <= nbig_s10[31:0];
			d2_s11        <= d2_s10;
			flg_s11.nneg  <= nneg_s10;
			flg_s11.ovf   <= nbig_s10[95:32] >= {2'd0, d2_s10};
			flg_s11.nzero <= nzero_s10;
			flg_s11.dzero <= dzero_s10;
		end
	end

endmodule

`default_nettype wire

@@ design/svau_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svau_div
// Restoring divider, two quotient bits per stage, followed by the rounding
// sign and saturation stage of one part.
// ----------------------------------------------------------------------------
module svau_div (
	input  wire                   clk,
	input  svau_pkg::stage_en_t   en,
	input  wire  [61:0]           rem_i,
	input  wire  [31:0]           nlo_i,
	input  wire  [61:0]           d2_i,
	input  svau_pkg::div_flags_t  flg_i,
	output logic [31:0]           new_vort_s28,
	output logic                  sat_s28
);
	import svau_pkg::*;

	logic [61:0] rem_s [DIV_STG];
	logic [31:0] nlo_s [DIV_STG];
	logic [31:0] quo_s [DIV_STG];
	logic [61:0] d2_s  [DIV_STG];
	div_flags_t  flg_s [DIV_STG];

	for (genvar j = 0; j < DIV_STG; j++) begin : g_div
		logic [61:0] rin, rt, d2in;
		logic [31:0] nin, nt, qin, qt;
		logic [62:0] t;
		div_flags_t  fin;

		if (j == 0) begin : g_head
			assign rin  = rem_i;
			assign nin  = nlo_i;
			assign qin  = '0;
			assign d2in = d2_i;
			assign fin  = flg_i;
		end else begin : g_body
			assign rin  = rem_s[j-1];
			assign nin  = nlo_s[j-1];
			assign qin  = quo_s[j-1];
			assign d2in = d2_s[j-1];
			assign fin  = flg_s[j-1];
		end

		// shift in a numerator bit, subtract the divisor where it fits
		always_comb begin
			rt = rin;
			nt = nin;
			qt = qin;
			t  = '0;
			for (int b = 0; b < DIV_BITS; b++) begin
				t  = {rt, nt[31]};
				nt = {nt[30:0], 1'b0};
				if (t >= {1'b0, d2in}) begin
					rt = 62'(t - {1'b0, d2in});
					qt = {qt[30:0], 1'b1};
				end else begin
					rt = t[61:0];
					qt = {qt[30:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[DIV_FIRST + j]) begin
				rem_s[j] <= rt;
				nlo_s[j] <= nt;
				quo_s[j] <= qt;
				d2_s[j]  <= d2in;
				flg_s[j] <= fin;
			end
		end
	end

	// sign and saturation
	logic [31:0] qf;
	div_flags_t  ff;
	logic [31:0] res;
	logic        sat;

	assign qf = quo_s[DIV_STG-1];
	assign ff = flg_s[DIV_STG-1];

	always_comb begin
		priority if (ff.dzero && ff.nzero) begin
			res = '0;
			sat = 1'b0;
		end else if (ff.dzero || ff.ovf) begin
			res = ff.nneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
			sat = 1'b1;
		end else if (!ff.nneg) begin
			sat = qf > 32'h7FFF_FFFF;
			res = sat ? 32'h7FFF_FFFF : qf;
		end else begin
			sat = qf > 32'h8000_0000;
			res = sat ? 32'h8000_0000 : 32'd0 - qf;
		end
	end

	always_ff @(posedge clk) begin
		if (en[DIV_FIRST + DIV_STG]) begin
			new_vort_s28 <= res;
			sat_s28      <= sat;
		end
	end

endmodule

`default_nettype wire

@@ design/spectral_cn_ab2_vorticity_update.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spectral_cn_ab2_vorticity_update
// Semi-implicit (Crank-Nicolson / Adams-Bashforth 2) update of one complex
// vorticity coefficient, Q16.16 with saturation, as a 28-stage pipeline.
//
//  channel  | dir | payload
//  ---------+-----+-----------------------------------------------------------
//  s_*      | in  | tdata: mode_x, mode_y, vort_re/im, flux_re/im, old_flux_re/im
//           |     | tuser: first_step
//  m_*      | out | tdata: new_vort_re, new_vort_im   tuser: saturated
//  cfg_*    | in  | 0 viscosity, 1 inv_time_step, 2 unit_wavenumber_sq
//
// One transfer per cycle in and out while the output is not stalled; each result
// passes 11 multiply stages and then the 16-stage radix-4 divider.
// Each stage holds its item until the next stage is free, so bubbles close
// up under output stalls and nothing is lost or repeated.
// Reset clears the valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module spectral_cn_ab2_vorticity_update (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	output logic         s_tready,
	input  wire  [207:0] s_tdata,   // mode_x, mode_y, vort_re, vort_im, flux_re,
	                                // flux_im, old_flux_re, old_flux_im
	input  wire  [0:0]   s_tuser,   // first_step
	output logic         m_tvalid,
	input  wire          m_tready,
	output logic [63:0]  m_tdata,   // new_vort_re, new_vort_im
	output logic [0:0]   m_tuser,   // saturated
	input  wire          cfg_we,
	input  wire  [1:0]   cfg_addr,
	input  wire  [30:0]  cfg_wdata
);
	import svau_pkg::*;

	// configuration registers
	logic [30:0] visc_q, inv_q, uwsq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visc_q <= VISC_RST;
			inv_q  <= INV_RST;
			uwsq_q <= UWSQ_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_VISC: visc_q <= cfg_wdata;
				CFG_INV:  inv_q  <= cfg_wdata;
				CFG_UWSQ: uwsq_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// valid bits and stage enables
	logic [N_STG:1]   vld_q;
	logic [N_STG+1:1] en_all;
	stage_en_t        en;

	always_comb begin
		en_all[N_STG+1] = m_tready;
		for (int k = N_STG; k >= 1; k--) begin
			en_all[k] = !vld_q[k] || en_all[k+1];
		end
	end

	assign en       = en_all[N_STG:1];
	assign s_tready = en_all[1];
	assign m_tvalid = vld_q[N_STG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) vld_q[1] <= s_tvalid;
			for (int k = 2; k <= N_STG; k++) begin
				if (en[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// stage 1: mode norm, flux combination, vorticity magnitudes
	logic signed [7:0]  mx, my;
	logic signed [15:0] sqx, sqy;
	logic signed [34:0] fr, fi, orr, oi;
	logic [31:0]        wr, wi;
	logic [15:0]        msq_s1;
	logic               wneg_re_s1, wneg_im_s1;
	logic [31:0]        wm_re_s1, wm_im_s1;
	logic signed [34:0] f2_re_s1, f2_im_s1;

	assign mx  = signed'(s_tdata[7:0]);
	assign my  = signed'(s_tdata[15:8]);
	assign sqx = 16'(mx) * 16'(mx);
	assign sqy = 16'(my) * 16'(my);
	assign wr  = s_tdata[47:16];
	assign wi  = s_tdata[79:48];
	assign fr  = signed'({{3{s_tdata[111]}}, s_tdata[111:80]});
	assign fi  = signed'({{3{s_tdata[143]}}, s_tdata[143:112]});
	assign orr = signed'({{3{s_tdata[175]}}, s_tdata[175:144]});
	assign oi  = signed'({{3{s_tdata[207]}}, s_tdata[207:176]});

	always_ff @(posedge clk) begin
		if (en[1]) begin
			msq_s1     <= unsigned'(sqx) + unsigned'(sqy);
			wneg_re_s1 <= wr[31];
			wneg_im_s1 <= wi[31];
			wm_re_s1   <= wr[31] ? 32'd0 - wr : wr;
			wm_im_s1   <= wi[31] ? 32'd0 - wi : wi;
			f2_re_s1   <= s_tuser[0] ? (fr <<< 1) : (fr + (fr <<< 1) - orr);
			f2_im_s1   <= s_tuser[0] ? (fi <<< 1) : (fi + (fi <<< 1) - oi);
		end
	end

	// shared factor and divisor
	logic [59:0] am_s5;
	logic        aneg_s5;
	logic [60:0] den_s5;

	svau_coef u_coef (
		.clk     (clk),
		.en      (en),
		.msq_s1  (msq_s1),
		.visc    (visc_q),
		.inv     (inv_q),
		.uwsq    (uwsq_q),
		.am_s5   (am_s5),
		.aneg_s5 (aneg_s5),
		.den_s5  (den_s5)
	);

	// real part
	logic [61:0] rem_re, d2_re;
	logic [31:0] nlo_re, nv_re;
	div_flags_t  flg_re;
	logic        sat_re;

	svau_numer u_numer_re (
		.clk     (clk),
		.en      (en),
		.wneg_s1 (wneg_re_s1),
		.wm_s1   (wm_re_s1),
		.f2_s1   (f2_re_s1),
		.am_s5   (am_s5),
		.aneg_s5 (aneg_s5),
		.den_s5  (den_s5),
		.rem_s11 (rem_re),
		.nlo_s11 (nlo_re),
		.d2_s11  (d2_re),
		.flg_s11 (flg_re)
	);

	svau_div u_div_re (
		.clk          (clk),
		.en           (en),
		.rem_i        (rem_re),
		.nlo_i        (nlo_re),
		.d2_i         (d2_re),
		.flg_i        (flg_re),
		.new_vort_s28 (nv_re),
		.sat_s28      (sat_re)
	);

	// imaginary part
	logic [61:0] rem_im, d2_im;
	logic [31:0] nlo_im, nv_im;
	div_flags_t  flg_im;
	logic        sat_im;

	svau_numer u_numer_im (
		.clk     (clk),
		.en      (en),
		.wneg_s1 (wneg_im_s1),
		.wm_s1   (wm_im_s1),
		.f2_s1   (f2_im_s1),
		.am_s5   (am_s5),
		.aneg_s5 (aneg_s5),
		.den_s5  (den_s5),
		.rem_s11 (rem_im),
		.nlo_s11 (nlo_im),
		.d2_s11  (d2_im),
		.flg_s11 (flg_im)
	);

	svau_div u_div_im (
		.clk          (clk),
		.en           (en),
		.rem_i        (rem_im),
		.nlo_i        (nlo_im),
		.d2_i         (d2_im),
		.flg_i        (flg_im),
		.new_vort_s28 (nv_im),
		.sat_s28      (sat_im)
	);

	assign m_tdata = {nv_im, nv_re};
	assign m_tuser = sat_re | sat_im;

`ifndef SYNTHESIS
	// the pipeline only refuses input when the result stage is held
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled without output back-pressure");

	// an accepted transfer lands in stage 1
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> vld_q[1])
		else $error("accepted transfer missing from stage 1");
`endif

endmodule

`default_nettype wire
